// ===== sv/uel_pkg.sv =====
// ---------------------------------------------------------------------------
// uel_pkg: shared types for the line envelope block
// controller states, command and status bundles, result kinds
// ---------------------------------------------------------------------------
package uel_pkg;

  localparam logic signed [63:0] VALUE_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_I_RD,
    ST_I_SEL,
    ST_H_START,
    ST_H_DIV,
    ST_H_CMP,
    ST_H_POP,
    ST_I_FIN,
    ST_Q_RD,
    ST_Q_CHK,
    ST_Q_MUL,
    ST_Q_ADD
  } uel_state_t;

  typedef enum logic [1:0] {
    RES_INS_OK,
    RES_INS_DROP,
    RES_EMPTY,
    RES_VALUE
  } resp_kind_t;

  typedef struct packed {
    logic       load;
    logic       rd_old;
    logic       cand_new;
    logic       cand_old;
    logic       skip_old;
    logic       push;
    logic       div_start;
    logic       pop;
    logic       pop_load;
    logic       commit;
    logic       q_rd;
    logic       q_chk;
    logic       mul;
    logic       resp;
    resp_kind_t kind;
  } uel_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic i_lt_cnt;
    logic placed;
    logic old_eq;
    logic old_ge;
    logic old_gt;
    logic h_zero;
    logic h_ge2;
    logic pop_ok;
    logic div_done;
    logic h_over;
    logic q_hit;
    logic q_last;
  } uel_status_t;

endpackage

// ===== sv/uel_div.sv =====
// ---------------------------------------------------------------------------
// uel_div: iterative floor divider
// signed 33-bit numerator by positive 33-bit denominator, one bit per cycle
// ---------------------------------------------------------------------------
module uel_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic        [32:0] den,
  output logic               done,
  output logic signed [33:0] quo
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [32:0] rem_r;
  logic [32:0] dvd_r;
  logic [32:0] den_r;
  logic        neg_r;
  logic [33:0] q_r;
  logic        done_r;
  logic [33:0] shifted;
  logic        fits;
  logic        rem_nz;

  assign shifted = {rem_r, dvd_r[32]};
  assign fits    = shifted >= {1'b0, den_r};
  assign rem_nz  = rem_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd33;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[32];
      dvd_r <= num[32] ? 33'(-num) : 33'(num);
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        // floor toward minus infinity on negative numerators
        q_r <= neg_r ? 34'(-({1'b0, dvd_r} + {33'd0, rem_nz})) : {1'b0, dvd_r};
      end else begin
        rem_r <= fits ? 33'(shifted - {1'b0, den_r}) : shifted[32:0];
        dvd_r <= {dvd_r[31:0], fits};
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== sv/uel_ctrl.sv =====
// ---------------------------------------------------------------------------
// uel_ctrl: sequencer for insert and query
// walks the merge, hull stack and query scan through the datapath
// ---------------------------------------------------------------------------
module uel_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_mode,
  input  uel_pkg::uel_status_t st,
  output logic                busy,
  output uel_pkg::uel_cmd_t   cmd
);
  import uel_pkg::*;

  uel_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!in_mode)         state_nxt = ST_I_RD;
          else if (!st.cnt_zero) state_nxt = ST_Q_RD;
        end
      end
      ST_I_RD: begin
        if (st.i_lt_cnt)     state_nxt = ST_I_SEL;
        else if (!st.placed) state_nxt = ST_H_START;
        else                 state_nxt = ST_I_FIN;
      end
      ST_I_SEL: begin
        priority if (st.old_eq)              state_nxt = st.old_ge ? ST_IDLE : ST_I_RD;
        else if (!st.placed && st.old_gt)    state_nxt = ST_H_START;
        else                                 state_nxt = ST_H_START;
      end
      ST_H_START: state_nxt = st.h_zero ? ST_I_RD : ST_H_DIV;
      ST_H_DIV:   if (st.div_done) state_nxt = ST_H_CMP;
      ST_H_CMP:   state_nxt = (st.h_ge2 && st.pop_ok) ? ST_H_POP : ST_I_RD;
      ST_H_POP:   state_nxt = ST_H_START;
      ST_I_FIN:   state_nxt = ST_IDLE;
      ST_Q_RD:    state_nxt = ST_Q_CHK;
      ST_Q_CHK:   state_nxt = (st.q_hit || st.q_last) ? ST_Q_MUL : ST_Q_RD;
      ST_Q_MUL:   state_nxt = ST_Q_ADD;
      ST_Q_ADD:   state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = RES_INS_OK;
    busy     = state_r != ST_IDLE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_mode && st.cnt_zero) begin
            cmd.resp = 1'b1;
            cmd.kind = RES_EMPTY;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_I_RD: begin
        if (st.i_lt_cnt)     cmd.rd_old   = 1'b1;
        else if (!st.placed) cmd.cand_new = 1'b1;
      end
      ST_I_SEL: begin
        priority if (st.old_eq) begin
          if (st.old_ge) cmd.resp     = 1'b1;
          else           cmd.skip_old = 1'b1;
        end else if (!st.placed && st.old_gt) begin
          cmd.cand_new = 1'b1;
        end else begin
          cmd.cand_old = 1'b1;
        end
      end
      ST_H_START: begin
        if (st.h_zero) cmd.push      = 1'b1;
        else           cmd.div_start = 1'b1;
      end
      ST_H_DIV: ;
      ST_H_CMP: begin
        if (st.h_ge2 && st.pop_ok) cmd.pop  = 1'b1;
        else                       cmd.push = 1'b1;
      end
      ST_H_POP: cmd.pop_load = 1'b1;
      ST_I_FIN: begin
        cmd.resp = 1'b1;
        if (st.h_over) cmd.kind = RES_INS_DROP;
        else           cmd.commit = 1'b1;
      end
      ST_Q_RD:  cmd.q_rd  = 1'b1;
      ST_Q_CHK: cmd.q_chk = 1'b1;
      ST_Q_MUL: cmd.mul   = 1'b1;
      ST_Q_ADD: begin
        cmd.resp = 1'b1;
        cmd.kind = RES_VALUE;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/uel_datapath.sv =====
// ---------------------------------------------------------------------------
// uel_datapath: line store, hull stack, divider and evaluator
// two banks of one memory, the new hull is built in the idle bank
// ---------------------------------------------------------------------------
module uel_datapath #(
  parameter int MAX_LINES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  uel_pkg::uel_cmd_t    cmd,
  output uel_pkg::uel_status_t st,
  input  logic signed [31:0]   in_slope,
  input  logic signed [31:0]   in_intercept,
  input  logic signed [31:0]   in_x_point,
  output logic                 out_strobe,
  output logic signed [63:0]   out_value,
  output logic                 out_empty_res,
  output logic                 out_dropped
);
  import uel_pkg::*;

  localparam int CW = $clog2(MAX_LINES + 2);
  localparam int AW = $clog2(MAX_LINES + 1);
  localparam int MD = 2 ** (AW + 1);
  localparam int LW = 98;

  logic [LW-1:0] line_mem_r [0:MD-1];

  logic          bank_r;
  logic [CW-1:0] cnt_r, i_r, h_r, j_r;
  logic          placed_r;
  logic          out_strobe_r;

  logic signed [31:0] s_r, b_r, x_r;
  logic signed [31:0] cand_s_r, cand_b_r, top_s_r, top_b_r;
  logic signed [31:0] prev_s_r, prev_b_r, sel_s_r, sel_b_r;
  logic signed [33:0] prevlim_r;
  logic signed [63:0] prod_r, value_r;
  logic               empty_r, dropped_r;
  logic [LW-1:0]      rd_q_r;

  logic signed [31:0] rd_s, rd_b;
  logic signed [33:0] rd_lim, push_lim, x_ext;
  logic [AW:0]        rd_addr, wr_addr;
  logic [CW-1:0]      h_m2, cnt_m1;
  logic               rd_en;
  logic signed [32:0] div_num;
  logic [32:0]        div_den;
  logic               div_done;
  logic signed [33:0] div_q;

  assign rd_s   = rd_q_r[97:66];
  assign rd_b   = rd_q_r[65:34];
  assign rd_lim = rd_q_r[33:0];
  assign x_ext  = {{2{x_r[31]}}, x_r};
  assign h_m2   = h_r - CW'(2);
  assign cnt_m1 = cnt_r - CW'(1);

  // crossing of the stack top with the candidate
  assign div_num = {top_b_r[31], top_b_r} - {cand_b_r[31], cand_b_r};
  assign div_den = 33'({cand_s_r[31], cand_s_r} - {top_s_r[31], top_s_r});

  uel_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    rd_addr = {bank_r, j_r[AW-1:0]};
    if (cmd.rd_old)   rd_addr = {bank_r, i_r[AW-1:0]};
    else if (cmd.pop) rd_addr = {~bank_r, h_m2[AW-1:0]};
  end
  assign rd_en    = cmd.rd_old | cmd.pop | cmd.q_rd;
  assign wr_addr  = {~bank_r, h_r[AW-1:0]};
  assign push_lim = (h_r == '0) ? '0 : div_q;

  assign st.cnt_zero = cnt_r == '0;
  assign st.i_lt_cnt = i_r < cnt_r;
  assign st.placed   = placed_r;
  assign st.old_eq   = rd_s == s_r;
  assign st.old_ge   = rd_b >= b_r;
  assign st.old_gt   = rd_s > s_r;
  assign st.h_zero   = h_r == '0;
  assign st.h_ge2    = h_r >= CW'(2);
  assign st.pop_ok   = prevlim_r >= div_q;
  assign st.div_done = div_done;
  assign st.h_over   = h_r > CW'(MAX_LINES);
  assign st.q_hit    = (j_r != '0) && (rd_lim >= x_ext);
  assign st.q_last   = j_r == cnt_m1;

  always_ff @(posedge clk) begin
    if (rd_en) rd_q_r <= line_mem_r[rd_addr];
    if (cmd.push) line_mem_r[wr_addr] <= {cand_s_r, cand_b_r, push_lim};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r       <= 1'b0;
      cnt_r        <= '0;
      i_r          <= '0;
      h_r          <= '0;
      j_r          <= '0;
      placed_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.resp;
      if (cmd.load) begin
        i_r      <= '0;
        h_r      <= '0;
        j_r      <= '0;
        placed_r <= 1'b0;
      end
      if (cmd.cand_new) placed_r <= 1'b1;
      if (cmd.cand_old || cmd.skip_old) i_r <= i_r + CW'(1);
      if (cmd.push) h_r <= h_r + CW'(1);
      if (cmd.pop)  h_r <= h_r - CW'(1);
      if (cmd.q_chk && !st.q_hit && !st.q_last) j_r <= j_r + CW'(1);
      if (cmd.commit) begin
        bank_r <= ~bank_r;
        cnt_r  <= h_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r <= in_slope;
      b_r <= in_intercept;
      x_r <= in_x_point;
    end
    if (cmd.cand_new) begin
      cand_s_r <= s_r;
      cand_b_r <= b_r;
    end
    if (cmd.cand_old) begin
      cand_s_r <= rd_s;
      cand_b_r <= rd_b;
    end
    if (cmd.push) begin
      top_s_r   <= cand_s_r;
      top_b_r   <= cand_b_r;
      prevlim_r <= push_lim;
    end
    if (cmd.pop_load) begin
      top_s_r   <= rd_s;
      top_b_r   <= rd_b;
      prevlim_r <= rd_lim;
    end
    if (cmd.q_chk) begin
      priority if (st.q_hit) begin
        sel_s_r <= prev_s_r;
        sel_b_r <= prev_b_r;
      end else if (st.q_last) begin
        sel_s_r <= rd_s;
        sel_b_r <= rd_b;
      end else begin
        prev_s_r <= rd_s;
        prev_b_r <= rd_b;
      end
    end
    if (cmd.mul) prod_r <= sel_s_r * x_r;
    if (cmd.resp) begin
      unique case (cmd.kind)
        RES_INS_OK: begin
          value_r <= '0; empty_r <= 1'b0; dropped_r <= 1'b0;
        end
        RES_INS_DROP: begin
          value_r <= '0; empty_r <= 1'b0; dropped_r <= 1'b1;
        end
        RES_EMPTY: begin
          value_r <= VALUE_MIN; empty_r <= 1'b1; dropped_r <= 1'b0;
        end
        RES_VALUE: begin
          value_r   <= prod_r + {{32{sel_b_r[31]}}, sel_b_r};
          empty_r   <= 1'b0;
          dropped_r <= 1'b0;
        end
        default: begin
          value_r <= '0; empty_r <= 1'b0; dropped_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_value     = value_r;
  assign out_empty_res = empty_r;
  assign out_dropped   = dropped_r;

endmodule

// ===== sv/upper_envelope_of_lines.sv =====
// ---------------------------------------------------------------------------
// upper_envelope_of_lines: max-query store of lines y = slope*x + intercept
// controller plus datapath, one item at a time, one result per item
// ---------------------------------------------------------------------------
// An item transfers on a clock edge with start high and busy low. Every
// item gives exactly one result, shown for one cycle with out_strobe high;
// the receiver cannot stall, so it must take each result in that cycle.
// A query scans the stored lines (up to line_count), reading and then
// checking each in turn, then multiplies and adds and registers the
// result; a query on an empty store answers the cycle after transfer.
// An insert visits each of up to line_count+1 candidate lines once and
// runs one floor division for every pop of the hull stack and for every
// push onto a non-empty stack; the serial divider and the single read
// port of the line memory set its length. busy drops when the result is
// issued, and the next item can transfer while that result is shown.
// ---------------------------------------------------------------------------
module upper_envelope_of_lines #(
  parameter int MAX_LINES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic signed [31:0] in_slope,
  input  logic signed [31:0] in_intercept,
  input  logic signed [31:0] in_x_point,
  output logic               out_strobe,
  output logic signed [63:0] out_value,
  output logic               out_empty_res,
  output logic               out_dropped
);
  import uel_pkg::*;

  // command and status between sequencer and datapath
  uel_cmd_t    cmd;
  uel_status_t st;

  uel_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .st      (st),
    .busy    (busy),
    .cmd     (cmd)
  );

  // line store, hull build and query evaluation
  uel_datapath #(
    .MAX_LINES (MAX_LINES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_slope      (in_slope),
    .in_intercept  (in_intercept),
    .in_x_point    (in_x_point),
    .out_strobe    (out_strobe),
    .out_value     (out_value),
    .out_empty_res (out_empty_res),
    .out_dropped   (out_dropped)
  );

endmodule
